### src/scpe_pkg.sv
package scpe_pkg;

    // coordinate and time formats
    localparam int COORD_W = 32;
    localparam int T_W     = 17;
    localparam logic [16:0] T_ONE = 17'h10000;

    // request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // configuration register indexes
    localparam logic REG_CURVE_TYPE  = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    // curve type codes
    typedef enum logic [2:0] {
        CURVE_NONE    = 3'd0,
        CURVE_STATIC  = 3'd1,
        CURVE_LINEAR  = 3'd2,
        CURVE_CATMULL = 3'd3,
        CURVE_BEZIER  = 3'd4,
        CURVE_BSPLINE = 3'd5
    } curve_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_POINT  = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_BAD_COUNT = 2'd3
    } status_t;

    // basis arithmetic constants (Q.48 numerators, Q.30 weights)
    localparam logic signed [53:0] ONE48  = 54'sh1000000000000;
    localparam logic signed [53:0] RND_CR = 54'sd262144;
    localparam logic signed [53:0] RND_BZ = 54'sd131072;
    localparam logic signed [53:0] RND_BS = 54'sd786432;
    localparam logic signed [31:0] W_ONE  = 32'sh40000000;
    localparam logic signed [65:0] RND_OUT = 66'sd536870912;
    localparam logic [63:0] RCP3 = 64'h00000000AAAAAAAB;

    typedef struct packed {
        logic                      func;
        logic [5:0]                point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [T_W-1:0]            t;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [1:0]                status;
    } out_t;

endpackage

### src/scpe_point_store.sv
module scpe_point_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic signed [31:0] wr_x,
    input  logic signed [31:0] wr_y,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr [4],
    output logic signed [31:0] rd_x [4],
    output logic signed [31:0] rd_y [4]
);

    // two identical banks, each with two read ports
    logic [63:0] bank0_mem [DEPTH];
    logic [63:0] bank1_mem [DEPTH];
    logic [63:0] rd_data_reg [4];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank0_mem[wr_addr] <= {wr_x, wr_y};
            bank1_mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en) begin
            rd_data_reg[0] <= bank0_mem[rd_addr[0]];
            rd_data_reg[1] <= bank0_mem[rd_addr[1]];
            rd_data_reg[2] <= bank1_mem[rd_addr[2]];
            rd_data_reg[3] <= bank1_mem[rd_addr[3]];
        end
    end

    // split into coordinates
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rd_x[i] = signed'(rd_data_reg[i][63:32]);
            rd_y[i] = signed'(rd_data_reg[i][31:0]);
        end
    end

endmodule

### src/spline_curve_point_evaluator_core.sv
// an accepted evaluate request passes stage registers 1 to 9 before m_valid
// throughput: one request per cycle unless m_ready stalls, loads and evaluates
//   alike, set by the nine-stage pipeline; loads write the store from stage 5
// reset: aresetn is synchronous and active low; it clears the pipeline valid
//   bits and both configuration registers, the point store is not cleared
module spline_curve_point_evaluator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [6:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  scpe_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output scpe_pkg::out_t  m_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // configuration registers
    logic [2:0] curve_type_reg;
    logic [6:0] point_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_type_reg  <= 3'd0;
            point_count_reg <= 7'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                scpe_pkg::REG_CURVE_TYPE:  curve_type_reg  <= cfg_wdata[2:0];
                scpe_pkg::REG_POINT_COUNT: point_count_reg <= cfg_wdata;
            endcase
        end
    end

    // pipeline valid bits and per-stage advance
    logic [9:1] vld_reg;
    logic [9:1] adv;

    always_comb begin
        adv[9] = !vld_reg[9] || m_ready;
        for (int i = 8; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[1];

    // stage registers
    scpe_pkg::in_t       s1_in_reg, s2_in_reg, s3_in_reg, s4_in_reg, s5_in_reg;
    logic [1:0]          s1_st_reg, s2_st_reg, s3_st_reg, s4_st_reg, s5_st_reg;
    logic [1:0]          s6_st_reg, s7_st_reg, s8_st_reg;
    logic [7:0]          s1_n_reg;
    logic                s1_last_reg;
    logic [16:0]         s1_frac_reg, s2_frac_reg, s2_u_reg, s3_frac_reg;
    logic [32:0]         s2_tt_reg, s2_uu_reg, s3_tt_reg;
    logic [48:0]         s3_t3_reg, s3_u3_reg, s3_tuu_reg, s3_ttu_reg;
    logic [AW-1:0]       s2_addr_reg [4];
    logic [AW-1:0]       s3_addr_reg [4];
    logic [AW-1:0]       s4_addr_reg [4];
    logic [AW-1:0]       s5_addr_reg [4];
    logic signed [31:0]  s4_w_reg [4];
    logic [31:0]         s4_bv_reg [4];
    logic signed [31:0]  s5_w_reg [4];
    logic signed [31:0]  s6_w_reg [4];
    logic signed [63:0]  s7_px_reg [4];
    logic signed [63:0]  s7_py_reg [4];
    logic signed [65:0]  s8_sx_reg, s8_sy_reg;
    scpe_pkg::out_t      out_reg;

    // stage 1: segment count, status, segment index and local time
    logic [6:0]  cm1_c;
    logic [12:0] bz_prod_c;
    logic [5:0]  bz_q_c;
    logic        cnt_over_c;
    logic [7:0]  nsegs_c;
    logic [1:0]  st_c;
    logic [16:0] tq_c;
    logic [24:0] prod_c;
    logic [8:0]  nraw_c;
    logic [7:0]  n_c;
    logic [16:0] frac_c;
    logic        last_c;

    always_comb begin
        cm1_c      = point_count_reg - 7'd1;
        bz_prod_c  = 13'(cm1_c) * 13'd43;
        bz_q_c     = bz_prod_c[12:7];
        cnt_over_c = (int'(point_count_reg) > MAX_POINTS);
        st_c       = scpe_pkg::ST_OK;
        nsegs_c    = 8'd1;
        unique case (curve_type_reg)
            scpe_pkg::CURVE_NONE: begin
                st_c = scpe_pkg::ST_NO_POINT;
            end
            scpe_pkg::CURVE_STATIC: begin
                st_c = scpe_pkg::ST_OK;
            end
            scpe_pkg::CURVE_LINEAR, scpe_pkg::CURVE_CATMULL: begin
                if (point_count_reg < 7'd2 || cnt_over_c) begin
                    st_c = scpe_pkg::ST_BAD_COUNT;
                end else begin
                    nsegs_c = 8'(cm1_c);
                end
            end
            scpe_pkg::CURVE_BEZIER: begin
                if (point_count_reg < 7'd4 || cm1_c != 7'(bz_q_c) * 7'd3 || cnt_over_c) begin
                    st_c = scpe_pkg::ST_BAD_COUNT;
                end else begin
                    nsegs_c = 8'(bz_q_c);
                end
            end
            scpe_pkg::CURVE_BSPLINE: begin
                if (point_count_reg == 7'd0 || cnt_over_c) begin
                    st_c = scpe_pkg::ST_BAD_COUNT;
                end else begin
                    nsegs_c = 8'(point_count_reg) + 8'd3;
                end
            end
            default: begin
                st_c = scpe_pkg::ST_BAD_TYPE;
            end
        endcase
        tq_c   = (s_data.t > scpe_pkg::T_ONE) ? scpe_pkg::T_ONE : s_data.t;
        prod_c = 25'(tq_c) * 25'(nsegs_c);
        nraw_c = prod_c[24:16];
        n_c    = (nraw_c >= {1'b0, nsegs_c}) ? nsegs_c - 8'd1 : nraw_c[7:0];
        frac_c = 17'(prod_c - 25'({n_c, 16'b0}));
        last_c = (n_c == nsegs_c - 8'd1);
    end

    // stage 2: complement, squares and point addresses
    logic [9:0]  nx_c, base_c, bs_c, kk_c;
    logic [9:0]  k_c [4];
    logic [16:0] u_c;

    always_comb begin
        nx_c   = {2'b00, s1_n_reg};
        base_c = nx_c + (nx_c << 1);
        bs_c   = 10'd0;
        kk_c   = 10'd0;
        for (int i = 0; i < 4; i++) begin
            k_c[i] = 10'd0;
        end
        unique case (curve_type_reg)
            scpe_pkg::CURVE_LINEAR: begin
                k_c[0] = nx_c;
                k_c[1] = nx_c + 10'd1;
                k_c[2] = nx_c;
                k_c[3] = nx_c;
            end
            scpe_pkg::CURVE_CATMULL: begin
                k_c[0] = (nx_c == 10'd0) ? 10'd0 : nx_c - 10'd1;
                k_c[1] = nx_c;
                k_c[2] = nx_c + 10'd1;
                k_c[3] = s1_last_reg ? nx_c + 10'd1 : nx_c + 10'd2;
            end
            scpe_pkg::CURVE_BEZIER: begin
                for (int i = 0; i < 4; i++) begin
                    k_c[i] = base_c + 10'(i);
                end
            end
            scpe_pkg::CURVE_BSPLINE: begin
                // end knots repeated: clamp n-3+i to the points in use
                for (int i = 0; i < 4; i++) begin
                    bs_c = nx_c + 10'(i);
                    kk_c = (bs_c < 10'd3) ? 10'd0 : bs_c - 10'd3;
                    if (kk_c >= {3'b000, point_count_reg}) begin
                        kk_c = {3'b000, point_count_reg} - 10'd1;
                    end
                    k_c[i] = kk_c;
                end
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    k_c[i] = 10'd0;
                end
            end
        endcase
        u_c = scpe_pkg::T_ONE - s1_frac_reg;
    end

    // stage 4: basis numerators and rounding to q.30
    logic signed [53:0] t1_c, t2_c, t3_c, u3_c, tuu_c, ttu_c;
    logic signed [53:0] num_c [4];
    logic signed [31:0] w_c [4];
    logic [31:0]        bv_c [4];

    always_comb begin
        t1_c  = signed'({5'b0, s3_frac_reg, 32'b0});
        t2_c  = signed'({5'b0, s3_tt_reg, 16'b0});
        t3_c  = signed'({5'b0, s3_t3_reg});
        u3_c  = signed'({5'b0, s3_u3_reg});
        tuu_c = signed'({5'b0, s3_tuu_reg});
        ttu_c = signed'({5'b0, s3_ttu_reg});
        for (int i = 0; i < 4; i++) begin
            num_c[i] = 54'sd0;
            w_c[i]   = 32'sd0;
            bv_c[i]  = 32'd0;
        end
        unique case (curve_type_reg)
            scpe_pkg::CURVE_STATIC: begin
                w_c[0] = scpe_pkg::W_ONE;
            end
            scpe_pkg::CURVE_LINEAR: begin
                w_c[0] = signed'({1'b0, (scpe_pkg::T_ONE - s3_frac_reg), 14'b0});
                w_c[1] = signed'({1'b0, s3_frac_reg, 14'b0});
            end
            scpe_pkg::CURVE_CATMULL: begin
                num_c[0] = -t1_c + (t2_c <<< 1) - t3_c;
                num_c[1] = (scpe_pkg::ONE48 <<< 1) - ((t2_c <<< 2) + t2_c)
                         + ((t3_c <<< 1) + t3_c);
                num_c[2] = t1_c + (t2_c <<< 2) - ((t3_c <<< 1) + t3_c);
                num_c[3] = t3_c - t2_c;
                for (int i = 0; i < 4; i++) begin
                    w_c[i] = 32'((num_c[i] + scpe_pkg::RND_CR) >>> 19);
                end
            end
            scpe_pkg::CURVE_BEZIER: begin
                num_c[0] = u3_c;
                num_c[1] = (tuu_c <<< 1) + tuu_c;
                num_c[2] = (ttu_c <<< 1) + ttu_c;
                num_c[3] = t3_c;
                for (int i = 0; i < 4; i++) begin
                    w_c[i] = 32'((num_c[i] + scpe_pkg::RND_BZ) >>> 18);
                end
            end
            scpe_pkg::CURVE_BSPLINE: begin
                // divide by 6<<18 as a shift by 19 here and a divide by 3 next stage
                num_c[0] = u3_c;
                num_c[1] = ((t3_c <<< 1) + t3_c) - ((t2_c <<< 2) + (t2_c <<< 1))
                         + (scpe_pkg::ONE48 <<< 2);
                num_c[2] = ((t2_c <<< 1) + t2_c) + ((t1_c <<< 1) + t1_c)
                         - ((t3_c <<< 1) + t3_c) + scpe_pkg::ONE48;
                num_c[3] = t3_c;
                for (int i = 0; i < 4; i++) begin
                    bv_c[i] = 32'((num_c[i] + scpe_pkg::RND_BS) >>> 19);
                end
            end
            default: begin
                w_c[0] = 32'sd0;
            end
        endcase
    end

    // stage 5: divide by 3 through the reciprocal for the b-spline
    logic [63:0]        q3_c [4];
    logic signed [31:0] w5_c [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q3_c[i] = 64'(s4_bv_reg[i]) * scpe_pkg::RCP3;
            w5_c[i] = (curve_type_reg == scpe_pkg::CURVE_BSPLINE) ?
                      signed'({1'b0, q3_c[i][63:33]}) : s4_w_reg[i];
        end
    end

    // point store, read when an item moves from stage 5 to stage 6
    logic               st_wr_en;
    logic signed [31:0] rd_x [4];
    logic signed [31:0] rd_y [4];

    assign st_wr_en = vld_reg[5] && adv[6] && (s5_in_reg.func == scpe_pkg::FUNC_LOAD)
                      && (int'(s5_in_reg.point_index) < MAX_POINTS);

    scpe_point_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (AW'(s5_in_reg.point_index)),
        .wr_x    (s5_in_reg.point_x),
        .wr_y    (s5_in_reg.point_y),
        .rd_en   (adv[6]),
        .rd_addr (s5_addr_reg),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    // stage 9: round half up to q16.16 and saturate
    function automatic logic signed [31:0] sat_round(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + scpe_pkg::RND_OUT) >>> 30;
        if (r > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (r < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(r);
    endfunction

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) vld_reg[1] <= s_valid;
            for (int i = 2; i <= 9; i++) begin
                if (adv[i]) begin
                    if (i == 6) begin
                        vld_reg[i] <= vld_reg[5] && (s5_in_reg.func == scpe_pkg::FUNC_EVAL);
                    end else begin
                        vld_reg[i] <= vld_reg[i-1];
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_in_reg   <= s_data;
            s1_st_reg   <= st_c;
            s1_n_reg    <= n_c;
            s1_frac_reg <= frac_c;
            s1_last_reg <= last_c;
        end
        if (adv[2]) begin
            s2_in_reg   <= s1_in_reg;
            s2_st_reg   <= s1_st_reg;
            s2_frac_reg <= s1_frac_reg;
            s2_u_reg    <= u_c;
            s2_tt_reg   <= 33'(s1_frac_reg) * 33'(s1_frac_reg);
            s2_uu_reg   <= 33'(u_c) * 33'(u_c);
            for (int i = 0; i < 4; i++) begin
                s2_addr_reg[i] <= (int'(k_c[i]) >= MAX_POINTS) ?
                                  AW'(MAX_POINTS - 1) : AW'(k_c[i]);
            end
        end
        if (adv[3]) begin
            s3_in_reg   <= s2_in_reg;
            s3_st_reg   <= s2_st_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_frac_reg <= s2_frac_reg;
            s3_tt_reg   <= s2_tt_reg;
            s3_t3_reg   <= 49'({17'b0, s2_tt_reg} * {33'b0, s2_frac_reg});
            s3_u3_reg   <= 49'({17'b0, s2_uu_reg} * {33'b0, s2_u_reg});
            s3_tuu_reg  <= 49'({17'b0, s2_uu_reg} * {33'b0, s2_frac_reg});
            s3_ttu_reg  <= 49'({17'b0, s2_tt_reg} * {33'b0, s2_u_reg});
        end
        if (adv[4]) begin
            s4_in_reg   <= s3_in_reg;
            s4_st_reg   <= s3_st_reg;
            s4_addr_reg <= s3_addr_reg;
            s4_w_reg    <= w_c;
            s4_bv_reg   <= bv_c;
        end
        if (adv[5]) begin
            s5_in_reg   <= s4_in_reg;
            s5_st_reg   <= s4_st_reg;
            s5_addr_reg <= s4_addr_reg;
            s5_w_reg    <= w5_c;
        end
        if (adv[6]) begin
            s6_st_reg <= s5_st_reg;
            s6_w_reg  <= s5_w_reg;
        end
        if (adv[7]) begin
            s7_st_reg <= s6_st_reg;
            for (int i = 0; i < 4; i++) begin
                s7_px_reg[i] <= 64'(s6_w_reg[i]) * 64'(rd_x[i]);
                s7_py_reg[i] <= 64'(s6_w_reg[i]) * 64'(rd_y[i]);
            end
        end
        if (adv[8]) begin
            s8_st_reg <= s7_st_reg;
            s8_sx_reg <= 66'(s7_px_reg[0]) + 66'(s7_px_reg[1])
                       + 66'(s7_px_reg[2]) + 66'(s7_px_reg[3]);
            s8_sy_reg <= 66'(s7_py_reg[0]) + 66'(s7_py_reg[1])
                       + 66'(s7_py_reg[2]) + 66'(s7_py_reg[3]);
        end
        if (adv[9]) begin
            out_reg.status <= s8_st_reg;
            if (s8_st_reg == scpe_pkg::ST_OK) begin
                out_reg.out_x <= sat_round(s8_sx_reg);
                out_reg.out_y <= sat_round(s8_sy_reg);
            end else begin
                out_reg.out_x <= 32'sd0;
                out_reg.out_y <= 32'sd0;
            end
        end
    end

    assign m_valid = vld_reg[9];
    assign m_data  = out_reg;

    // input stalls only when every stage is full and the result is held
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with room in the pipeline");

    // failed requests carry no coordinates
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != scpe_pkg::ST_OK |->
            m_data.out_x == 32'sd0 && m_data.out_y == 32'sd0)
        else $error("error result with nonzero point");

    // a blocked sum stage keeps its contents
    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[8] && !adv[9] |=> vld_reg[8] && $stable(s8_sx_reg) && $stable(s8_sy_reg))
        else $error("sum stage lost data under stall");

endmodule

### dv/spline_curve_point_evaluator_checker.sv
module spline_curve_point_evaluator_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [6:0]     cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  scpe_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  scpe_pkg::out_t m_data,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    NPTS      = 64;
    localparam longint Q48_UNIT = 64'sd1 <<< 48;

    // shadow copy of the block state
    logic [2:0]     shape;
    logic [6:0]     npoints;
    longint         px [NPTS];
    longint         py [NPTS];
    scpe_pkg::out_t curve_q[$];

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half - 1) >>> s);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic int clamp_ix(int k, int cnt);
        if (k < 0) k = 0;
        if (k >= cnt) k = cnt - 1;
        return k;
    endfunction

    // curve point for one evaluate request
    function automatic scpe_pkg::out_t curve_point(scpe_pkg::in_t d);
        scpe_pkg::out_t r;
        int     cnt, nsegs, n;
        int     k [4];
        longint w [4];
        longint tq, prod, tt, uu, t1, t2, t3, ax, ay;
        logic   bad;
        r = '0;
        bad = 1'b0;
        nsegs = 1;
        cnt = int'(npoints);
        tq = longint'(d.t);
        if (tq > 65536) tq = 65536;
        case (shape)
            scpe_pkg::CURVE_NONE: begin
                r.status = scpe_pkg::ST_NO_POINT;
                return r;
            end
            scpe_pkg::CURVE_STATIC: begin
                r.out_x = clip32(px[0]);
                r.out_y = clip32(py[0]);
                r.status = scpe_pkg::ST_OK;
                return r;
            end
            scpe_pkg::CURVE_LINEAR, scpe_pkg::CURVE_CATMULL: begin
                nsegs = cnt - 1;
                bad = (nsegs < 1);
            end
            scpe_pkg::CURVE_BEZIER: begin
                nsegs = (cnt - 1) / 3;
                bad = (cnt < 4) || ((cnt - 1) % 3 != 0);
            end
            scpe_pkg::CURVE_BSPLINE: begin
                nsegs = cnt + 3;
                bad = (cnt < 1);
            end
            default: begin
                r.status = scpe_pkg::ST_BAD_TYPE;
                return r;
            end
        endcase
        if (cnt > NPTS) bad = 1'b1;
        if (bad) begin
            r.status = scpe_pkg::ST_BAD_COUNT;
            return r;
        end

        // segment select and local time
        prod = tq * nsegs;
        n = int'(prod >>> 16);
        if (n >= nsegs) n = nsegs - 1;
        tt = prod - (longint'(n) <<< 16);
        uu = 65536 - tt;
        t1 = tt <<< 32;
        t2 = (tt * tt) <<< 16;
        t3 = tt * tt * tt;

        // basis weights in Q.30
        if (shape == scpe_pkg::CURVE_LINEAR) begin
            k = '{n, n + 1, n, n};
            w = '{uu <<< 14, tt <<< 14, 0, 0};
        end else if (shape == scpe_pkg::CURVE_CATMULL) begin
            k[0] = (n == 0) ? n : n - 1;
            k[1] = n;
            k[2] = n + 1;
            k[3] = (n == nsegs - 1) ? n + 1 : n + 2;
            w[0] = round_shift(-t1 + 2 * t2 - t3, 19);
            w[1] = round_shift(2 * Q48_UNIT - 5 * t2 + 3 * t3, 19);
            w[2] = round_shift(t1 + 4 * t2 - 3 * t3, 19);
            w[3] = round_shift(-t2 + t3, 19);
        end else if (shape == scpe_pkg::CURVE_BEZIER) begin
            for (int i = 0; i < 4; i++) k[i] = 3 * n + i;
            w[0] = round_shift(uu * uu * uu, 18);
            w[1] = round_shift(3 * tt * uu * uu, 18);
            w[2] = round_shift(3 * tt * tt * uu, 18);
            w[3] = round_shift(t3, 18);
        end else begin
            for (int i = 0; i < 4; i++) k[i] = clamp_ix(n - 3 + i, cnt);
            w[0] = (uu * uu * uu + (64'sd3 <<< 18)) / (64'sd6 <<< 18);
            w[1] = (3 * t3 - 6 * t2 + 4 * Q48_UNIT + (64'sd3 <<< 18)) / (64'sd6 <<< 18);
            w[2] = (-3 * t3 + 3 * t2 + 3 * t1 + Q48_UNIT + (64'sd3 <<< 18))
                   / (64'sd6 <<< 18);
            w[3] = (t3 + (64'sd3 <<< 18)) / (64'sd6 <<< 18);
        end

        // weighted sum, then round to Q16.16
        ax = 0;
        ay = 0;
        for (int i = 0; i < 4; i++) begin
            ax += w[i] * px[clamp_ix(k[i], NPTS)];
            ay += w[i] * py[clamp_ix(k[i], NPTS)];
        end
        r.out_x = clip32(round_shift(ax, 30));
        r.out_y = clip32(round_shift(ay, 30));
        r.status = scpe_pkg::ST_OK;
        return r;
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        shape = scpe_pkg::CURVE_NONE;
        npoints = '0;
        for (int i = 0; i < NPTS; i++) begin
            px[i] = 0;
            py[i] = 0;
        end
    end

    // follow config, requests and results
    always @(posedge aclk) begin
        scpe_pkg::out_t want;
        if (!aresetn) begin
            shape = scpe_pkg::CURVE_NONE;
            npoints = '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == scpe_pkg::REG_CURVE_TYPE) shape = cfg_wdata[2:0];
                else npoints = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                if (s_data.func == scpe_pkg::FUNC_LOAD) begin
                    px[s_data.point_index] = longint'(s_data.point_x);
                    py[s_data.point_index] = longint'(s_data.point_y);
                end else begin
                    curve_q.push_back(curve_point(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (curve_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_data);
                end else begin
                    want = curve_q.pop_front();
                    if (want.out_x !== m_data.out_x) begin
                        errors++;
                        $display("%0t: out_x expected %h actual %h", $time,
                                 want.out_x, m_data.out_x);
                    end
                    if (want.out_y !== m_data.out_y) begin
                        errors++;
                        $display("%0t: out_y expected %h actual %h", $time,
                                 want.out_y, m_data.out_y);
                    end
                    if (want.status !== m_data.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_data.status);
                    end
                end
            end
        end
        pending = curve_q.size();
    end
endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 20;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    logic           cfg_index;
    logic [6:0]     cfg_wdata;
    logic           s_valid;
    logic           s_ready;
    scpe_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    scpe_pkg::out_t m_data;
    int             errors;
    int             pending;
    int             idle_cycles;
    int             burst_left;
    bit             loaded [64];

    spline_curve_point_evaluator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    spline_curve_point_evaluator_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side stalls, in one of four randomly drawn modes that are redrawn in turn
    initial begin
        int mode;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat (64) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send(scpe_pkg::in_t d);
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        if (d.func == scpe_pkg::FUNC_LOAD) loaded[d.point_index] = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic load_point(int ix, logic [31:0] x, logic [31:0] y);
        scpe_pkg::in_t d;
        d = '0;
        d.func = scpe_pkg::FUNC_LOAD;
        d.point_index = ix[5:0];
        d.point_x = x;
        d.point_y = y;
        d.t = 17'($urandom);
        send(d);
    endtask

    task automatic eval_at(logic [16:0] tv);
        scpe_pkg::in_t d;
        d = '0;
        d.func = scpe_pkg::FUNC_EVAL;
        d.point_index = 6'($urandom);
        d.point_x = $urandom;
        d.point_y = $urandom;
        d.t = tv;
        send(d);
    endtask

    // wait out every result and the load path before touching config;
    // pending is sampled mid-cycle, after the checker has seen the edge
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_curve(logic [2:0] ct, logic [6:0] cnt);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= scpe_pkg::REG_CURVE_TYPE;
        cfg_wdata <= {4'd0, ct};
        @(posedge aclk);
        cfg_index <= scpe_pkg::REG_POINT_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // length of the written run from slot 0
    function automatic int written_prefix();
        for (int i = 0; i < 64; i++) if (!loaded[i]) return i;
        return 64;
    endfunction

    function automatic logic [6:0] pick_count(logic [2:0] ct, int p);
        int r;
        r = $urandom_range(0, 127);
        // an in-range count never reaches past the written points
        if (r <= 64 && r > p) r = p;
        if ($urandom_range(0, 5) == 0) return 7'(r);
        case (ct)
            scpe_pkg::CURVE_LINEAR, scpe_pkg::CURVE_CATMULL:
                return 7'($urandom_range(2, p));
            scpe_pkg::CURVE_BEZIER: return 7'(1 + 3 * $urandom_range(1, (p - 1) / 3));
            scpe_pkg::CURVE_BSPLINE: return 7'($urandom_range(1, p));
            default: return 7'(r);
        endcase
    endfunction

    initial begin
        logic [2:0]  ct;
        logic [6:0]  cnt;
        logic [31:0] vx, vy;
        int          p;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = scpe_pkg::REG_CURVE_TYPE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        idle_cycles = 0;
        burst_left = 8;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config gives no point
        eval_at(17'd0);
        load_point(0, 32'h7fffffff, 32'h80000000);
        load_point(1, 32'h80000000, 32'h7fffffff);
        load_point(2, 32'h00000000, 32'hffffffff);
        load_point(3, 32'h00010000, 32'hfffe0000);
        for (int i = 4; i < 16; i++) load_point(i, $urandom, $urandom_range(0, 65535));
        load_point(63, 32'h00000001, 32'h80000001);
        set_curve(scpe_pkg::CURVE_STATIC, 7'd0);
        eval_at(17'h1ffff);
        set_curve(scpe_pkg::CURVE_LINEAR, 7'd2);
        eval_at(17'd0);
        eval_at(scpe_pkg::T_ONE);
        eval_at(17'h1ffff);
        set_curve(scpe_pkg::CURVE_CATMULL, 7'd3);
        eval_at(17'h08000);
        set_curve(scpe_pkg::CURVE_BEZIER, 7'd4);
        eval_at(17'h0ffff);
        set_curve(scpe_pkg::CURVE_BSPLINE, 7'd1);
        eval_at(17'h04000);
        set_curve(3'd7, 7'd127);
        eval_at(17'd1);

        // random phases, each with its own curve setting
        for (int ph = 0; ph < 12; ph++) begin
            p = written_prefix();
            ct = (ph == 11) ? 3'(scpe_pkg::CURVE_BSPLINE) : 3'($urandom_range(0, 7));
            cnt = (ph == 11 && p == 64) ? 7'd64 : pick_count(ct, p);
            set_curve(ct, cnt);
            repeat (150) begin
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        vx = $urandom;
                        vy = $urandom;
                    end else begin
                        vx = 32'($signed($urandom_range(0, 2097151)) - 1048576);
                        vy = 32'($signed($urandom_range(0, 2097151)) - 1048576);
                    end
                    load_point($urandom_range(0, 63), vx, vy);
                end else begin
                    case ($urandom_range(0, 9))
                        0: eval_at(17'($urandom_range(65537, 131071)));
                        1: eval_at(scpe_pkg::T_ONE);
                        2: eval_at(17'd0);
                        default: eval_at(17'($urandom_range(0, 65535)));
                    endcase
                end
            end
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
